@@ rtl/task_block_pool_allocator_unit_assert.svh @@
// Assertion macros shared by the task block pool allocator RTL.
`ifndef TASK_BLOCK_POOL_ALLOCATOR_UNIT_ASSERT_SVH
`define TASK_BLOCK_POOL_ALLOCATOR_UNIT_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define TBPA_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("task block pool allocator assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define TBPA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("task block pool allocator assertion failed");

`endif

@@ rtl/tbpa_pkg.sv @@
// Types, constants and codes of the task block pool allocator.
package tbpa_pkg;

    localparam int POOL_BLOCKS = 32;
    localparam int ID_W        = $clog2(POOL_BLOCKS);
    localparam int CNT_W       = ID_W + 1;

    typedef logic [ID_W-1:0]  t_id;
    typedef logic [CNT_W-1:0] t_cnt;

    // Pool size as a count; also the null marker of the critical list.
    localparam t_cnt POOL_CNT = t_cnt'(POOL_BLOCKS);
    localparam t_cnt NULL_IDX = t_cnt'(POOL_BLOCKS);

    localparam logic [1:0] CMD_ALLOC = 2'd0;
    localparam logic [1:0] CMD_FREE  = 2'd1;
    localparam logic [1:0] CMD_QUERY = 2'd2;

    localparam logic [1:0] RC_OK        = 2'd0;
    localparam logic [1:0] RC_EMPTY     = 2'd1;
    localparam logic [1:0] RC_FULL      = 2'd2;
    localparam logic [1:0] RC_NOT_ALLOC = 2'd3;

    localparam logic [2:0] ST_FREE      = 3'd0;
    localparam logic [2:0] ST_ALLOCATED = 3'd1;

    // Criticality strictly above this level marks a critical task.
    localparam logic [1:0] CRIT_THRESH = 2'd1;

    typedef struct packed {
        logic [1:0] command;
        logic [1:0] job_kind;
        logic [1:0] crit_lvl;
        logic [4:0] blk_id;
    } t_in;

    typedef struct packed {
        logic [1:0] result_code;
        logic [4:0] granted_id;
        logic [2:0] block_state;
        logic [5:0] free_blocks;
        logic [5:0] critical_tasks;
    } t_out;

    typedef struct packed {
        logic [1:0] job;
        logic [2:0] status;
        logic [1:0] crit;
    } t_blk;

    typedef struct packed {
        t_id  blk;
        t_cnt nxt;
    } t_ce;

    typedef struct packed {
        logic en;
        t_id  addr;
        t_id  data;
    } t_lifo_wr;

    typedef enum logic [2:0] {
        S_IDLE,
        S_READ,
        S_EXEC,
        S_WALK,
        S_UNLINK,
        S_RESP
    } t_state;

endpackage

@@ rtl/task_block_pool_allocator_unit.sv @@
// An accepted command passes through the read, execute and response states; a critical free
// also walks the critical list one entry per cycle through the list memory's read port and
// unlinks a matching entry. o_stall holds off the next command until the response is loaded.
// A result waiting in the output register does not block the next input transfer.
// Synchronous active-low reset: pool full, stacks hold their indexes, list empty.
module task_block_pool_allocator_unit (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_stall,
    input  tbpa_pkg::t_in  i_data,
    output logic           o_valid,
    input  logic           i_stall,
    output tbpa_pkg::t_out o_data
);

    tbpa_pkg::t_state r_state, n_state;
    tbpa_pkg::t_in    r_req;
    tbpa_pkg::t_cnt   r_free_count, n_free_count;
    tbpa_pkg::t_cnt   r_cfree_count, n_cfree_count;
    tbpa_pkg::t_cnt   r_crit_count, n_crit_count;
    tbpa_pkg::t_cnt   r_head, n_head;
    tbpa_pkg::t_cnt   r_prev, n_prev;
    tbpa_pkg::t_id    r_cur, n_cur;
    tbpa_pkg::t_id    r_prev_blk, n_prev_blk;
    tbpa_pkg::t_cnt   r_steps, n_steps;
    logic [1:0]       r_rc, n_rc;
    tbpa_pkg::t_id    r_gid, n_gid;
    logic [2:0]       r_st, n_st;
    logic             r_out_valid, n_out_valid;
    tbpa_pkg::t_out   r_out;

    tbpa_pkg::t_blk                   r_blk_mem [tbpa_pkg::POOL_BLOCKS];
    logic [tbpa_pkg::POOL_BLOCKS-1:0] r_blk_vld;
    tbpa_pkg::t_blk                   r_blk_q;
    tbpa_pkg::t_ce                    r_ce_mem [tbpa_pkg::POOL_BLOCKS];
    tbpa_pkg::t_ce                    r_ce_q;

    logic               accept;
    logic               load;
    logic               blk_rd_en;
    logic               blk_wr_en;
    tbpa_pkg::t_id      blk_wr_addr;
    tbpa_pkg::t_blk     blk_wr_data;
    logic               ce_rd_en;
    tbpa_pkg::t_id      ce_rd_addr;
    logic               ce_wr_en;
    tbpa_pkg::t_id      ce_wr_addr;
    tbpa_pkg::t_ce      ce_wr_data;
    logic               fs_rd_en;
    tbpa_pkg::t_id      fs_rd_addr;
    tbpa_pkg::t_id      fs_q;
    tbpa_pkg::t_lifo_wr fs_wr;
    logic               cfs_rd_en;
    tbpa_pkg::t_id      cfs_rd_addr;
    tbpa_pkg::t_id      cfs_q;
    tbpa_pkg::t_lifo_wr cfs_wr;
    tbpa_pkg::t_cnt     step;

    assign o_stall = (r_state != tbpa_pkg::S_IDLE);
    assign accept  = i_valid && !o_stall;
    assign o_valid = r_out_valid;
    assign o_data  = r_out;
    assign step    = r_steps + 1'b1;

    // Block id free stack and critical list entry free stack.
    tbpa_lifo_mem u_free_stack (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_en   (fs_rd_en),
        .i_rd_addr (fs_rd_addr),
        .o_rd_data (fs_q),
        .i_wr      (fs_wr)
    );

    tbpa_lifo_mem u_crit_free_stack (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_en   (cfs_rd_en),
        .i_rd_addr (cfs_rd_addr),
        .o_rd_data (cfs_q),
        .i_wr      (cfs_wr)
    );

    // Block descriptor memory; an entry never written reads as all zero.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_blk_vld <= '0;
        end else if (blk_wr_en) begin
            r_blk_vld[blk_wr_addr] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (blk_wr_en) begin
            r_blk_mem[blk_wr_addr] <= blk_wr_data;
        end
        if (blk_rd_en) begin
            r_blk_q <= r_blk_vld[r_req.blk_id] ? r_blk_mem[r_req.blk_id] : '0;
        end
    end

    // Critical list entry memory.
    always_ff @(posedge i_clk) begin
        if (ce_wr_en) begin
            r_ce_mem[ce_wr_addr] <= ce_wr_data;
        end
        if (ce_rd_en) begin
            r_ce_q <= r_ce_mem[ce_rd_addr];
        end
    end

    always_comb begin
        n_state       = r_state;
        n_free_count  = r_free_count;
        n_cfree_count = r_cfree_count;
        n_crit_count  = r_crit_count;
        n_head        = r_head;
        n_prev        = r_prev;
        n_cur         = r_cur;
        n_prev_blk    = r_prev_blk;
        n_steps       = r_steps;
        n_rc          = r_rc;
        n_gid         = r_gid;
        n_st          = r_st;
        load          = 1'b0;
        blk_rd_en     = 1'b0;
        blk_wr_en     = 1'b0;
        blk_wr_addr   = r_req.blk_id;
        blk_wr_data   = '0;
        ce_rd_en      = 1'b0;
        ce_rd_addr    = r_cur;
        ce_wr_en      = 1'b0;
        ce_wr_addr    = r_cur;
        ce_wr_data    = '0;
        fs_rd_en      = 1'b0;
        fs_rd_addr    = tbpa_pkg::t_id'(r_free_count - 1'b1);
        fs_wr         = '0;
        cfs_rd_en     = 1'b0;
        cfs_rd_addr   = tbpa_pkg::t_id'(r_cfree_count - 1'b1);
        cfs_wr        = '0;

        case (r_state)
            tbpa_pkg::S_IDLE: begin
                if (accept) begin
                    n_state = tbpa_pkg::S_READ;
                end
            end

            tbpa_pkg::S_READ: begin
                blk_rd_en = 1'b1;
                fs_rd_en  = 1'b1;
                cfs_rd_en = 1'b1;
                n_state   = tbpa_pkg::S_EXEC;
            end

            tbpa_pkg::S_EXEC: begin
                n_rc    = tbpa_pkg::RC_OK;
                n_gid   = r_req.blk_id;
                n_st    = tbpa_pkg::ST_FREE;
                n_state = tbpa_pkg::S_RESP;
                case (r_req.command)
                    tbpa_pkg::CMD_ALLOC: begin
                        if (r_free_count == '0) begin
                            n_rc  = tbpa_pkg::RC_EMPTY;
                            n_gid = '0;
                        end else begin
                            n_free_count = r_free_count - 1'b1;
                            blk_wr_en    = 1'b1;
                            blk_wr_addr  = fs_q;
                            blk_wr_data  = '{job:    r_req.job_kind,
                                             status: tbpa_pkg::ST_ALLOCATED,
                                             crit:   r_req.crit_lvl};
                            if (r_req.crit_lvl > tbpa_pkg::CRIT_THRESH &&
                                r_cfree_count != '0) begin
                                ce_wr_en      = 1'b1;
                                ce_wr_addr    = cfs_q;
                                ce_wr_data    = '{blk: fs_q, nxt: r_head};
                                n_head        = {1'b0, cfs_q};
                                n_cfree_count = r_cfree_count - 1'b1;
                                n_crit_count  = r_crit_count + 1'b1;
                            end
                            n_gid = fs_q;
                            n_st  = tbpa_pkg::ST_ALLOCATED;
                        end
                    end

                    tbpa_pkg::CMD_FREE: begin
                        // Every 5-bit id lies inside the pool, so no range check is needed.
                        if (r_free_count >= tbpa_pkg::POOL_CNT) begin
                            n_rc = tbpa_pkg::RC_FULL;
                            n_st = r_blk_q.status;
                        end else if (r_blk_q.status == tbpa_pkg::ST_FREE) begin
                            n_rc = tbpa_pkg::RC_NOT_ALLOC;
                        end else begin
                            fs_wr.en     = 1'b1;
                            fs_wr.addr   = tbpa_pkg::t_id'(r_free_count);
                            fs_wr.data   = r_req.blk_id;
                            n_free_count = r_free_count + 1'b1;
                            blk_wr_en    = 1'b1;
                            if (r_blk_q.crit > tbpa_pkg::CRIT_THRESH &&
                                r_head < tbpa_pkg::NULL_IDX) begin
                                ce_rd_en   = 1'b1;
                                ce_rd_addr = tbpa_pkg::t_id'(r_head);
                                n_cur      = tbpa_pkg::t_id'(r_head);
                                n_prev     = tbpa_pkg::NULL_IDX;
                                n_steps    = '0;
                                n_state    = tbpa_pkg::S_WALK;
                            end
                        end
                    end

                    default: begin
                        n_st = r_blk_q.status;
                    end
                endcase
            end

            tbpa_pkg::S_WALK: begin
                if (r_ce_q.blk == r_req.blk_id) begin
                    // Unlink the entry from its predecessor or from the head.
                    if (r_prev >= tbpa_pkg::NULL_IDX) begin
                        n_head = r_ce_q.nxt;
                    end else begin
                        ce_wr_en   = 1'b1;
                        ce_wr_addr = tbpa_pkg::t_id'(r_prev);
                        ce_wr_data = '{blk: r_prev_blk, nxt: r_ce_q.nxt};
                    end
                    if (r_cfree_count < tbpa_pkg::POOL_CNT) begin
                        cfs_wr.en     = 1'b1;
                        cfs_wr.addr   = tbpa_pkg::t_id'(r_cfree_count);
                        cfs_wr.data   = r_cur;
                        n_cfree_count = r_cfree_count + 1'b1;
                    end
                    if (r_crit_count != '0) begin
                        n_crit_count = r_crit_count - 1'b1;
                    end
                    n_state = tbpa_pkg::S_UNLINK;
                end else if (r_ce_q.nxt >= tbpa_pkg::NULL_IDX ||
                             step >= tbpa_pkg::POOL_CNT) begin
                    // End of list or walk bound reached: the block stays freed.
                    n_state = tbpa_pkg::S_RESP;
                end else begin
                    ce_rd_en   = 1'b1;
                    ce_rd_addr = tbpa_pkg::t_id'(r_ce_q.nxt);
                    n_cur      = tbpa_pkg::t_id'(r_ce_q.nxt);
                    n_prev     = {1'b0, r_cur};
                    n_prev_blk = r_ce_q.blk;
                    n_steps    = step;
                end
            end

            tbpa_pkg::S_UNLINK: begin
                ce_wr_en   = 1'b1;
                ce_wr_addr = r_cur;
                ce_wr_data = '{blk: '0, nxt: tbpa_pkg::NULL_IDX};
                n_state    = tbpa_pkg::S_RESP;
            end

            tbpa_pkg::S_RESP: begin
                if (!r_out_valid || !i_stall) begin
                    load    = 1'b1;
                    n_state = tbpa_pkg::S_IDLE;
                end
            end

            default: begin
                n_state = tbpa_pkg::S_IDLE;
            end
        endcase

        n_out_valid = (r_out_valid && i_stall) || load;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= tbpa_pkg::S_IDLE;
            r_free_count  <= tbpa_pkg::POOL_CNT;
            r_cfree_count <= tbpa_pkg::POOL_CNT;
            r_crit_count  <= '0;
            r_head        <= tbpa_pkg::NULL_IDX;
            r_out_valid   <= 1'b0;
        end else begin
            r_state       <= n_state;
            r_free_count  <= n_free_count;
            r_cfree_count <= n_cfree_count;
            r_crit_count  <= n_crit_count;
            r_head        <= n_head;
            r_out_valid   <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_req <= i_data;
        end
        r_prev     <= n_prev;
        r_cur      <= n_cur;
        r_prev_blk <= n_prev_blk;
        r_steps    <= n_steps;
        r_rc       <= n_rc;
        r_gid      <= n_gid;
        r_st       <= n_st;
        if (load) begin
            r_out <= '{result_code:    r_rc,
                       granted_id:     r_gid,
                       block_state:    r_st,
                       free_blocks:    r_free_count,
                       critical_tasks: r_crit_count};
        end
    end

`include "task_block_pool_allocator_unit_assert.svh"

    `TBPA_ASSERT_SAME(a_free_count_bound, i_clk, i_rst_n, 1'b1, r_free_count <= tbpa_pkg::POOL_CNT)
    `TBPA_ASSERT_SAME(a_crit_entries_balance, i_clk, i_rst_n, 1'b1, r_crit_count == tbpa_pkg::POOL_CNT - r_cfree_count)
    `TBPA_ASSERT_SAME(a_walk_bounded, i_clk, i_rst_n, r_state == tbpa_pkg::S_WALK, r_steps < tbpa_pkg::POOL_CNT)
    `TBPA_ASSERT_NEXT(a_accept_starts_read, i_clk, i_rst_n, accept, r_state == tbpa_pkg::S_READ)

endmodule

@@ rtl/tbpa_lifo_mem.sv @@
// Id stack memory whose entries read as their own index until first written.
module tbpa_lifo_mem (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_rd_en,
    input  tbpa_pkg::t_id      i_rd_addr,
    output tbpa_pkg::t_id      o_rd_data,
    input  tbpa_pkg::t_lifo_wr i_wr
);

    tbpa_pkg::t_id                     r_mem [tbpa_pkg::POOL_BLOCKS];
    logic [tbpa_pkg::POOL_BLOCKS-1:0]  r_vld;
    tbpa_pkg::t_id                     r_q;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_wr.en) begin
            r_vld[i_wr.addr] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_mem[i_wr.addr] <= i_wr.data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_q <= r_vld[i_rd_addr] ? r_mem[i_rd_addr] : i_rd_addr;
        end
    end

    assign o_rd_data = r_q;

endmodule

@@ sim/task_block_pool_allocator_unit_tb.sv @@
// Self-checking testbench for the task block pool allocator: directed table, then random traffic.
module task_block_pool_allocator_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CLK_PERIOD = 8;
    localparam int RANDOM_ITEMS = 950;
    localparam int DRAIN_CYCLES = 40;
    localparam int IDLE_PCT = 31;

    // Command 3 is decoded as a query.
    localparam logic [1:0] CMD_QUERY_ALT = 2'd3;

    localparam logic [1:0] JOB_NONE    = 2'd0;
    localparam logic [1:0] JOB_FFT     = 2'd1;
    localparam logic [1:0] JOB_VITERBI = 2'd2;

    typedef enum logic [1:0] {
        MIX_FILL,
        MIX_DRAIN,
        MIX_EVEN
    } t_traffic_mix;

    typedef struct packed {
        tbpa_pkg::t_in  item;
        logic           typed;
        tbpa_pkg::t_out want;
    } t_directed_row;

    logic           i_clk   = 1'b0;
    logic           i_rst_n = 1'b0;
    logic           i_valid = 1'b0;
    logic           i_stall = 1'b0;
    tbpa_pkg::t_in  i_data  = '0;
    logic           o_stall;
    logic           o_valid;
    tbpa_pkg::t_out o_data;

    // Both sides stop idling while this is set.
    logic steady = 1'b0;

    int unsigned    n_fail = 0;
    tbpa_pkg::t_out pending_results[$];
    t_directed_row  directed_rows[$];
    tbpa_pkg::t_out next_want;

    // Shadow of the pool and of the critical list.
    tbpa_pkg::t_id  pool_free_ids[tbpa_pkg::POOL_BLOCKS];
    tbpa_pkg::t_cnt pool_free_cnt;
    logic [1:0]     pool_job[tbpa_pkg::POOL_BLOCKS];
    logic [2:0]     pool_status[tbpa_pkg::POOL_BLOCKS];
    logic [1:0]     pool_crit[tbpa_pkg::POOL_BLOCKS];
    tbpa_pkg::t_id  crit_owner[tbpa_pkg::POOL_BLOCKS];
    tbpa_pkg::t_cnt crit_link[tbpa_pkg::POOL_BLOCKS];
    tbpa_pkg::t_cnt crit_first;
    tbpa_pkg::t_id  crit_spare_ids[tbpa_pkg::POOL_BLOCKS];
    tbpa_pkg::t_cnt crit_spare_cnt;
    tbpa_pkg::t_cnt crit_live;

    task_block_pool_allocator_unit dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_data  (i_data),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_data  (o_data)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    function automatic void clear_pool_shadow();
        for (int i = 0; i < tbpa_pkg::POOL_BLOCKS; i++) begin
            pool_free_ids[i]  = tbpa_pkg::t_id'(i);
            crit_spare_ids[i] = tbpa_pkg::t_id'(i);
            pool_job[i]       = JOB_NONE;
            pool_status[i]    = tbpa_pkg::ST_FREE;
            pool_crit[i]      = '0;
            crit_owner[i]     = '0;
            crit_link[i]      = '0;
        end
        pool_free_cnt  = tbpa_pkg::POOL_CNT;
        crit_spare_cnt = tbpa_pkg::POOL_CNT;
        crit_first     = tbpa_pkg::NULL_IDX;
        crit_live      = '0;
    endfunction

    // Walks the critical list from the head and unlinks the entry that owns the block.
    function automatic void unlink_critical_block(tbpa_pkg::t_id bid);
        tbpa_pkg::t_cnt prev;
        tbpa_pkg::t_cnt cur;
        int             steps;
        prev  = tbpa_pkg::NULL_IDX;
        cur   = crit_first;
        steps = 0;
        while (cur < tbpa_pkg::POOL_CNT && steps < tbpa_pkg::POOL_BLOCKS &&
               crit_owner[tbpa_pkg::t_id'(cur)] != bid) begin
            prev = cur;
            cur  = crit_link[tbpa_pkg::t_id'(cur)];
            steps++;
        end
        if (cur >= tbpa_pkg::POOL_CNT || steps >= tbpa_pkg::POOL_BLOCKS) return;
        if (prev >= tbpa_pkg::POOL_CNT) crit_first = crit_link[tbpa_pkg::t_id'(cur)];
        else crit_link[tbpa_pkg::t_id'(prev)] = crit_link[tbpa_pkg::t_id'(cur)];
        crit_owner[tbpa_pkg::t_id'(cur)] = '0;
        crit_link[tbpa_pkg::t_id'(cur)]  = tbpa_pkg::NULL_IDX;
        if (crit_spare_cnt < tbpa_pkg::POOL_CNT) begin
            crit_spare_ids[tbpa_pkg::t_id'(crit_spare_cnt)] = tbpa_pkg::t_id'(cur);
            crit_spare_cnt++;
        end
        if (crit_live > 0) crit_live--;
    endfunction

    function automatic tbpa_pkg::t_out predict_pool_command(tbpa_pkg::t_in c);
        tbpa_pkg::t_out r;
        tbpa_pkg::t_id  b;
        tbpa_pkg::t_id  li;
        r             = '0;
        r.result_code = tbpa_pkg::RC_OK;
        r.granted_id  = c.blk_id;
        r.block_state = tbpa_pkg::ST_FREE;
        if (c.command == tbpa_pkg::CMD_ALLOC) begin
            if (pool_free_cnt == 0) begin
                r.result_code = tbpa_pkg::RC_EMPTY;
                r.granted_id  = '0;
            end else begin
                b = pool_free_ids[tbpa_pkg::t_id'(pool_free_cnt - 1'b1)];
                pool_free_cnt--;
                pool_job[b]    = c.job_kind;
                pool_status[b] = tbpa_pkg::ST_ALLOCATED;
                pool_crit[b]   = c.crit_lvl;
                if (c.crit_lvl > tbpa_pkg::CRIT_THRESH && crit_spare_cnt > 0) begin
                    li = crit_spare_ids[tbpa_pkg::t_id'(crit_spare_cnt - 1'b1)];
                    crit_spare_cnt--;
                    crit_owner[li] = b;
                    crit_link[li]  = crit_first;
                    crit_first     = tbpa_pkg::t_cnt'(li);
                    crit_live++;
                end
                r.granted_id  = b;
                r.block_state = tbpa_pkg::ST_ALLOCATED;
            end
        end else if (c.command == tbpa_pkg::CMD_FREE) begin
            if (pool_free_cnt >= tbpa_pkg::POOL_CNT) begin
                r.result_code = tbpa_pkg::RC_FULL;
                r.block_state = pool_status[c.blk_id];
            end else if (pool_status[c.blk_id] == tbpa_pkg::ST_FREE) begin
                r.result_code = tbpa_pkg::RC_NOT_ALLOC;
            end else begin
                pool_free_ids[tbpa_pkg::t_id'(pool_free_cnt)] = c.blk_id;
                pool_free_cnt++;
                if (pool_crit[c.blk_id] > tbpa_pkg::CRIT_THRESH) unlink_critical_block(c.blk_id);
                pool_job[c.blk_id]    = JOB_NONE;
                pool_status[c.blk_id] = tbpa_pkg::ST_FREE;
                pool_crit[c.blk_id]   = '0;
            end
        end else begin
            r.block_state = pool_status[c.blk_id];
        end
        r.free_blocks    = pool_free_cnt;
        r.critical_tasks = crit_live;
        return r;
    endfunction

    // Random command; frees mostly target live blocks so that the list walk gets exercised.
    function automatic tbpa_pkg::t_in draw_random_command(t_traffic_mix mix);
        tbpa_pkg::t_in c;
        int unsigned   roll;
        int unsigned   alloc_pct;
        int unsigned   free_pct;
        tbpa_pkg::t_id live_ids[$];
        c.job_kind = 2'($urandom_range(JOB_VITERBI));
        c.crit_lvl = 2'($urandom_range(3));
        c.blk_id   = 5'($urandom_range(tbpa_pkg::POOL_BLOCKS - 1));
        case (mix)
            MIX_FILL: begin
                alloc_pct = 80;
                free_pct  = 12;
            end
            MIX_DRAIN: begin
                alloc_pct = 12;
                free_pct  = 78;
            end
            default: begin
                alloc_pct = 42;
                free_pct  = 45;
            end
        endcase
        roll = $urandom_range(99);
        if (roll < alloc_pct) begin
            c.command = tbpa_pkg::CMD_ALLOC;
        end else if (roll < alloc_pct + free_pct) begin
            c.command = tbpa_pkg::CMD_FREE;
            for (int i = 0; i < tbpa_pkg::POOL_BLOCKS; i++)
                if (pool_status[i] != tbpa_pkg::ST_FREE) live_ids.push_back(tbpa_pkg::t_id'(i));
            if (live_ids.size() != 0 && $urandom_range(99) < 85)
                c.blk_id = live_ids[$urandom_range(live_ids.size() - 1)];
        end else begin
            c.command = ($urandom_range(9) == 0) ? CMD_QUERY_ALT : tbpa_pkg::CMD_QUERY;
        end
        return c;
    endfunction

    task automatic add_row(logic [1:0] cmd, logic [1:0] job, logic [1:0] crit,
                           logic [4:0] bid, logic typed = 1'b0,
                           logic [1:0] rc = tbpa_pkg::RC_OK, logic [4:0] gid = '0,
                           logic [2:0] st = tbpa_pkg::ST_FREE,
                           tbpa_pkg::t_cnt fb = '0, tbpa_pkg::t_cnt ct = '0);
        t_directed_row row;
        row.item  = '{command: cmd, job_kind: job, crit_lvl: crit, blk_id: bid};
        row.typed = typed;
        row.want  = '{result_code: rc, granted_id: gid, block_state: st,
                      free_blocks: fb, critical_tasks: ct};
        directed_rows.push_back(row);
    endtask

    // Presents one command, waits for its transfer and records what it should return.
    task automatic send_command(tbpa_pkg::t_in c, logic typed, tbpa_pkg::t_out want);
        tbpa_pkg::t_out predicted;
        while (!steady && $urandom_range(99) < IDLE_PCT) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_data  <= c;
        do @(posedge i_clk); while (o_stall !== 1'b0);
        predicted = predict_pool_command(c);
        pending_results.push_back(typed ? want : predicted);
    endtask

    task automatic check_field(string name, logic [7:0] want_v, logic [7:0] got_v);
        if (want_v !== got_v) begin
            $error("%s: expected %0d, got %0d", name, want_v, got_v);
            n_fail++;
        end
    endtask

    always @(posedge i_clk) begin
        i_stall <= !steady && ($urandom_range(99) < IDLE_PCT);
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_results.size() == 0) begin
                $error("result transfer with no command outstanding");
                n_fail++;
            end else begin
                next_want = pending_results.pop_front();
                check_field("result_code", 8'(next_want.result_code), 8'(o_data.result_code));
                check_field("granted_id", 8'(next_want.granted_id), 8'(o_data.granted_id));
                check_field("block_state", 8'(next_want.block_state), 8'(o_data.block_state));
                check_field("free_blocks", 8'(next_want.free_blocks), 8'(o_data.free_blocks));
                check_field("critical_tasks", 8'(next_want.critical_tasks),
                            8'(o_data.critical_tasks));
            end
        end
    end

    initial begin
        t_traffic_mix  mix;
        int            burst_left;
        tbpa_pkg::t_in c;
        clear_pool_shadow();
        mix        = MIX_FILL;
        burst_left = 0;

        // Fresh pool, full-pool frees, then a small critical list of three entries.
        add_row(tbpa_pkg::CMD_QUERY, JOB_NONE, 2'd0, 5'd0, 1'b1, tbpa_pkg::RC_OK, 5'd0,
                tbpa_pkg::ST_FREE, tbpa_pkg::POOL_CNT, 6'd0);
        add_row(CMD_QUERY_ALT, JOB_NONE, 2'd0, 5'd31, 1'b1, tbpa_pkg::RC_OK, 5'd31,
                tbpa_pkg::ST_FREE, tbpa_pkg::POOL_CNT, 6'd0);
        add_row(tbpa_pkg::CMD_FREE, JOB_NONE, 2'd0, 5'd31, 1'b1, tbpa_pkg::RC_FULL, 5'd31,
                tbpa_pkg::ST_FREE, tbpa_pkg::POOL_CNT, 6'd0);
        add_row(tbpa_pkg::CMD_FREE, JOB_NONE, 2'd0, 5'd0, 1'b1, tbpa_pkg::RC_FULL, 5'd0,
                tbpa_pkg::ST_FREE, tbpa_pkg::POOL_CNT, 6'd0);
        add_row(tbpa_pkg::CMD_ALLOC, JOB_VITERBI, 2'd3, 5'd0, 1'b1, tbpa_pkg::RC_OK, 5'd31,
                tbpa_pkg::ST_ALLOCATED, 6'd31, 6'd1);
        add_row(tbpa_pkg::CMD_ALLOC, JOB_FFT, 2'd2, 5'd31, 1'b1, tbpa_pkg::RC_OK, 5'd30,
                tbpa_pkg::ST_ALLOCATED, 6'd30, 6'd2);
        add_row(tbpa_pkg::CMD_ALLOC, JOB_NONE, 2'd1, 5'd0, 1'b1, tbpa_pkg::RC_OK, 5'd29,
                tbpa_pkg::ST_ALLOCATED, 6'd29, 6'd2);
        add_row(tbpa_pkg::CMD_ALLOC, JOB_VITERBI, 2'd0, 5'd0, 1'b1, tbpa_pkg::RC_OK, 5'd28,
                tbpa_pkg::ST_ALLOCATED, 6'd28, 6'd2);
        add_row(tbpa_pkg::CMD_ALLOC, JOB_FFT, 2'd3, 5'd0, 1'b1, tbpa_pkg::RC_OK, 5'd27,
                tbpa_pkg::ST_ALLOCATED, 6'd27, 6'd3);
        add_row(tbpa_pkg::CMD_QUERY, JOB_NONE, 2'd0, 5'd31, 1'b1, tbpa_pkg::RC_OK, 5'd31,
                tbpa_pkg::ST_ALLOCATED, 6'd27, 6'd3);
        add_row(tbpa_pkg::CMD_FREE, JOB_NONE, 2'd0, 5'd5, 1'b1, tbpa_pkg::RC_NOT_ALLOC, 5'd5,
                tbpa_pkg::ST_FREE, 6'd27, 6'd3);
        // The oldest critical block sits at the tail, so this free walks the whole list.
        add_row(tbpa_pkg::CMD_FREE, JOB_NONE, 2'd0, 5'd31);
        add_row(tbpa_pkg::CMD_FREE, JOB_NONE, 2'd0, 5'd31, 1'b1, tbpa_pkg::RC_NOT_ALLOC, 5'd31,
                tbpa_pkg::ST_FREE, 6'd28, 6'd2);
        add_row(tbpa_pkg::CMD_FREE, JOB_NONE, 2'd0, 5'd27);
        add_row(tbpa_pkg::CMD_FREE, JOB_NONE, 2'd0, 5'd29);
        add_row(tbpa_pkg::CMD_ALLOC, JOB_NONE, 2'd2, 5'd0);
        add_row(tbpa_pkg::CMD_FREE, JOB_NONE, 2'd0, 5'd30);
        add_row(tbpa_pkg::CMD_QUERY, JOB_NONE, 2'd0, 5'd0);
        add_row(tbpa_pkg::CMD_ALLOC, JOB_VITERBI, 2'd3, 5'd31);
        add_row(tbpa_pkg::CMD_FREE, JOB_NONE, 2'd0, 5'd28);
        add_row(tbpa_pkg::CMD_QUERY, JOB_NONE, 2'd0, 5'd29);

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed_rows[i])
            send_command(directed_rows[i].item, directed_rows[i].typed, directed_rows[i].want);

        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            steady = (n >= 400 && n < 520);
            if (burst_left == 0) begin
                mix        = t_traffic_mix'($urandom_range(MIX_EVEN));
                burst_left = $urandom_range(60, 20);
            end
            burst_left--;
            c = draw_random_command(mix);
            send_command(c, 1'b0, '0);
        end
        steady  = 1'b0;
        i_valid <= 1'b0;

        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (n_fail == 0) $display("TB_OK");
        else $display("TB_ERROR");
        $finish;
    end

    initial begin
        #5_000_000;
        $display("TB_ERROR");
        $finish;
    end

endmodule
